FILE: rtl/core/sts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted table search block.
// Used by sts_front, sts_queue, sts_back and the top level.

package sts_pkg;

	localparam int KEY_W   = 32;
	localparam int IDX_W   = 8;
	localparam int BND_W   = IDX_W + 1;
	localparam int MODE_W  = 2;
	localparam int CFGI_W  = 2;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 48;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EXACT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd2;

	localparam logic [CFGI_W-1:0] CFG_RANGE_FIRST = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_RANGE_LAST  = 2'd1;

	localparam logic [IDX_W-1:0] RANGE_FIRST_RST = 8'd0;
	localparam logic [IDX_W-1:0] RANGE_LAST_RST  = 8'd255;

	// One classified command: a table write or a search with its bounds.
	// Search bounds are half open: lo is the first index, hend one past the last.
	typedef struct packed {
		logic                    is_load;
		logic                    ceil;
		logic [IDX_W-1:0]        index;
		logic signed [KEY_W-1:0] key;
		logic [BND_W-1:0]        lo;
		logic [BND_W-1:0]        hend;
	} cmd_t;

endpackage

FILE: rtl/core/sts_front.sv
`timescale 1ns / 1ps
// Front end: input beat acceptance, mode decode and search bound setup.
// Holds the range registers. Depends on sts_pkg.

module sts_front #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sts_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [sts_pkg::IDX_W-1:0]     cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sts_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic [sts_pkg::MODE_W-1:0]    s_axis_tuser,
	input  logic                          q_ready,
	output logic                          push,
	output sts_pkg::cmd_t                 push_cmd
);
	import sts_pkg::*;

	logic [IDX_W-1:0]        range_first_q;
	logic [IDX_W-1:0]        range_last_q;
	logic [IDX_W-1:0]        entry_index;
	logic signed [KEY_W-1:0] key;
	logic                    keep;
	logic                    accept;
	logic [BND_W-1:0]        hend0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= RANGE_FIRST_RST;
			range_last_q  <= RANGE_LAST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RANGE_FIRST: range_first_q <= cfg_wdata;
				CFG_RANGE_LAST:  range_last_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign entry_index   = s_axis_tdata[IDX_W-1:0];
	assign key           = s_axis_tdata[IDX_W +: KEY_W];
	assign s_axis_tready = q_ready;
	assign accept        = s_axis_tvalid && q_ready;

	// Clip the last index to the table; a first index past it leaves the range empty.
	assign hend0 = (TABLE_DEPTH <= int'(range_last_q)) ? BND_W'(TABLE_DEPTH)
		: ({1'b0, range_last_q} + BND_W'(1));

	// Drop unused modes and loads that fall outside the table.
	always_comb begin
		case (s_axis_tuser)
			MODE_LOAD:  keep = int'(entry_index) < TABLE_DEPTH;
			MODE_EXACT: keep = 1'b1;
			MODE_CEIL:  keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign push = accept && keep;

	always_comb begin
		push_cmd.is_load = (s_axis_tuser == MODE_LOAD);
		push_cmd.ceil    = (s_axis_tuser == MODE_CEIL);
		push_cmd.index   = entry_index;
		push_cmd.key     = key;
		push_cmd.lo      = {1'b0, range_first_q};
		push_cmd.hend    = hend0;
	end

endmodule

FILE: rtl/core/sts_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between front end and search engine.
// Depends on sts_pkg for the command type.

module sts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sts_pkg::cmd_t  push_cmd,
	output logic           q_ready,
	input  logic           pop,
	output logic           head_valid,
	output sts_pkg::cmd_t  head_cmd
);
	import sts_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready    = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/core/sts_back.sv
`timescale 1ns / 1ps
// Search engine: table memory, one probe per cycle, result register.
// Depends on sts_pkg; fed by sts_queue.

module sts_back #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  sts_pkg::cmd_t                head_cmd,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [sts_pkg::OUT_W-1:0]    m_axis_tdata
);
	import sts_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	function automatic logic [IDX_W-1:0] midpoint(input logic [BND_W-1:0] lo,
			input logic [BND_W-1:0] hend);
		logic [BND_W-1:0] sum;
		sum = lo + hend - BND_W'(1);
		return sum[BND_W-1:1];
	endfunction

	logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
	logic signed [KEY_W-1:0] rdata_q;
	logic [AW-1:0]           rd_addr;

	logic                    state_q;
	logic [BND_W-1:0]        lo_q;
	logic [BND_W-1:0]        hend_q;
	logic [IDX_W-1:0]        mid_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    ceil_q;
	logic                    best_found_q;
	logic [IDX_W-1:0]        best_pos_q;
	logic signed [KEY_W-1:0] best_val_q;

	logic                    out_valid_q;
	logic                    out_found_q;
	logic [IDX_W-1:0]        out_pos_q;
	logic signed [KEY_W-1:0] out_val_q;

	logic                    out_free;
	logic                    do_load;
	logic                    start;
	logic                    start_empty;
	logic [IDX_W-1:0]        mid0;
	logic                    hit_eq;
	logic                    hit_lt;
	logic                    gt_rec;
	logic [BND_W-1:0]        lo_nx;
	logic [BND_W-1:0]        hend_nx;
	logic                    more;
	logic [IDX_W-1:0]        mid_nx;
	logic                    probe_done;
	logic                    best_found_nx;
	logic [IDX_W-1:0]        best_pos_nx;
	logic signed [KEY_W-1:0] best_val_nx;

	assign out_free    = !out_valid_q || m_axis_tready;
	assign do_load     = (state_q == ST_IDLE) && head_valid && head_cmd.is_load;
	assign start       = (state_q == ST_IDLE) && head_valid && !head_cmd.is_load && out_free;
	assign pop         = do_load || start;
	assign start_empty = !(head_cmd.lo < head_cmd.hend);
	assign mid0        = midpoint(head_cmd.lo, head_cmd.hend);

	assign hit_eq  = (rdata_q == key_q);
	assign hit_lt  = (rdata_q < key_q);
	assign gt_rec  = ceil_q && !hit_eq && !hit_lt;
	assign lo_nx   = hit_lt ? ({1'b0, mid_q} + BND_W'(1)) : lo_q;
	assign hend_nx = (!hit_lt && !hit_eq) ? {1'b0, mid_q} : hend_q;
	assign more    = (lo_nx < hend_nx);
	assign mid_nx  = midpoint(lo_nx, hend_nx);

	assign probe_done    = (state_q == ST_PROBE) && (hit_eq || !more);
	assign best_found_nx = gt_rec ? 1'b1 : best_found_q;
	assign best_pos_nx   = gt_rec ? mid_q : best_pos_q;
	assign best_val_nx   = gt_rec ? rdata_q : best_val_q;

	assign rd_addr = (state_q == ST_IDLE) ? AW'(mid0) : AW'(mid_nx);

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[AW'(head_cmd.index)] <= head_cmd.key;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:  if (start && !start_empty) state_q <= ST_PROBE;
				ST_PROBE: if (probe_done) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if ((start && start_empty) || probe_done) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lo_q         <= head_cmd.lo;
			hend_q       <= head_cmd.hend;
			mid_q        <= mid0;
			key_q        <= head_cmd.key;
			ceil_q       <= head_cmd.ceil;
			best_found_q <= 1'b0;
			best_pos_q   <= '0;
			best_val_q   <= '0;
		end else if (state_q == ST_PROBE) begin
			lo_q         <= lo_nx;
			hend_q       <= hend_nx;
			mid_q        <= mid_nx;
			best_found_q <= best_found_nx;
			best_pos_q   <= best_pos_nx;
			best_val_q   <= best_val_nx;
		end

		if (start && start_empty) begin
			out_found_q <= 1'b0;
			out_pos_q   <= '0;
			out_val_q   <= '0;
		end else if (probe_done) begin
			// An equal entry ends the search; otherwise report the best ceiling seen (none in exact mode, a miss).
			if (hit_eq) begin
				out_found_q <= 1'b1;
				out_pos_q   <= mid_q;
				out_val_q   <= rdata_q;
			end else begin
				out_found_q <= best_found_nx;
				out_pos_q   <= best_pos_nx;
				out_val_q   <= best_val_nx;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - KEY_W - IDX_W - 1)'(0), out_val_q, out_pos_q, out_found_q};

`ifndef SYNTHESIS
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> lo_q < hend_q)
		else $error("probe with empty bounds");

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> ({1'b0, mid_q} >= lo_q && {1'b0, mid_q} < hend_q))
		else $error("probe index outside bounds");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> (out_pos_q == '0 && out_val_q == '0))
		else $error("miss result carries nonzero payload");

	a_exact_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && hit_eq) |=>
		(out_valid_q && out_found_q && out_val_q == $past(key_q)))
		else $error("equal probe did not yield matching result");
`endif

endmodule

FILE: rtl/core/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Sorted table binary search: loads an ascending table and answers
// exact and ceiling queries. Depends on sts_pkg, sts_front, sts_queue, sts_back.
//
// Usage:
//   Input beats arrive on s_axis_*: tuser selects load, exact or ceiling;
//   tdata carries the table index and the key. A load writes one entry and
//   returns nothing; a query returns one beat on m_axis_* with found,
//   position and value (position and value are zero on a miss). Unused
//   modes and loads beyond the table are accepted and dropped.
//   The search range comes from the range_first / range_last registers on
//   the cfg_* write port; write them only while the block is idle.
// Timing:
//   The front end pushes beats into a two-entry queue. The search engine
//   takes one load per cycle while idle with loads at the queue head; a query
//   is issued and then probes the table, at most floor(log2(span)) + 1 probes
//   (9 for a full 256-entry range), and none for an empty range. The loop
//   through the table memory's registered read port paces the probes.
//   The result appears in the output register the cycle after the last probe.
// Reset and stalls:
//   Reset sets range_first to 0 and range_last to 255 and empties the queue
//   and the result register; table contents are undefined until loaded.
//   While a result is held on m_axis_*, the engine starts no new query; the
//   queue keeps taking beats until full, then s_axis_tready drops.

module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,    // [7:0] entry_index, [39:8] key
	input  logic [1:0]  s_axis_tuser,    // [1:0] mode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata     // [0] found, [8:1] position, [40:9] entry_value
);
	import sts_pkg::*;

	logic q_ready;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// Decode beats and build search bounds from the range registers.
	sts_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_ready       (q_ready),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// Decouple acceptance from the search loop; loads stay in order with queries.
	sts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Write the table and run the probes; hold each result until taken.
	sts_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
